@@ hw/rtl/tterm_pkg.sv @@
// ----------------------------------------------------------------------------
// tterm_pkg
// Shared types, geometry constants and character codes of the text terminal.
// ----------------------------------------------------------------------------
package tterm_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  // holds a column that has stepped past the last one, tab included
  localparam int NEXT_W = $clog2(COLUMNS + TAB_WIDTH);
  localparam int TAB_STOPS = (COLUMNS - 1) / TAB_WIDTH + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 2'd1;

  localparam logic [3:0] BACK_RESET = 4'h0;
  localparam logic [3:0] FORE_RESET = 4'hF;

  localparam logic [15:0] BLANK_WORD = 16'h0F20;

  localparam logic [7:0] CHR_BS        = 8'h08;
  localparam logic [7:0] CHR_TAB       = 8'h09;
  localparam logic [7:0] CHR_LF        = 8'h0A;
  localparam logic [7:0] CHR_CR        = 8'h0D;
  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] CHR_PRINT_MAX = 8'h7F;

  typedef enum logic [1:0] {
    ACT_PUT       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_BACKSPACE = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_location;
  } out_item_t;

  // what a request does to the cell store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              scroll;
  } plan_t;

  // cursor as reported in a result
  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] location;
  } cursor_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

@@ hw/rtl/tterm_ram.sv @@
// ----------------------------------------------------------------------------
// tterm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tterm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tterm_cursor.sv @@
// ----------------------------------------------------------------------------
// tterm_cursor
// Cursor registers and the per-request cursor move and cell write decision.
// ----------------------------------------------------------------------------
module tterm_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tterm_pkg::in_item_t item_i,
  input  logic [3:0]         back_i,
  input  logic [3:0]         fore_i,
  output tterm_pkg::plan_t   plan_o,
  output tterm_pkg::cursor_t cursor_o
);

  logic [tterm_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tterm_pkg::COL_W-1:0]  col_q, col_d;
  logic [tterm_pkg::COL_W-1:0]  col_dec;
  logic [tterm_pkg::NEXT_W-1:0] col_n, tab_next;
  logic [tterm_pkg::ROW_W:0]    row_n;
  logic [7:0]                   code;

  assign code    = item_i.char_code;
  assign col_dec = (col_q != '0) ? col_q - 1'b1 : '0;

  // next tab stop, always at least one step on
  always_comb begin
    tab_next = tterm_pkg::NEXT_W'(tterm_pkg::TAB_STOPS * tterm_pkg::TAB_WIDTH);
    for (int k = tterm_pkg::TAB_STOPS; k >= 1; k--) begin
      if (tterm_pkg::NEXT_W'(col_q) < tterm_pkg::NEXT_W'(k * tterm_pkg::TAB_WIDTH)) begin
        tab_next = tterm_pkg::NEXT_W'(k * tterm_pkg::TAB_WIDTH);
      end
    end
  end

  always_comb begin
    col_n          = tterm_pkg::NEXT_W'(col_q);
    row_n          = (tterm_pkg::ROW_W + 1)'(row_q);
    plan_o.wr_en   = 1'b0;
    plan_o.wr_addr = tterm_pkg::cell_addr(row_q, col_q);
    plan_o.wr_data = {back_i, fore_i, code};
    plan_o.scroll  = 1'b0;
    case (item_i.action)
      tterm_pkg::ACT_PUT: begin
        if (code == tterm_pkg::CHR_BS) begin
          col_n = tterm_pkg::NEXT_W'(col_dec);
        end else if (code == tterm_pkg::CHR_TAB) begin
          col_n = tab_next;
        end else if (code == tterm_pkg::CHR_CR) begin
          col_n = '0;
        end else if (code == tterm_pkg::CHR_LF) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end else if (code >= tterm_pkg::CHR_SPACE && code <= tterm_pkg::CHR_PRINT_MAX) begin
          plan_o.wr_en = 1'b1;
          col_n        = col_n + 1'b1;
        end
        // line wrap, then scroll off the bottom
        if (col_n >= tterm_pkg::NEXT_W'(tterm_pkg::COLUMNS)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end
        if (row_n >= (tterm_pkg::ROW_W + 1)'(tterm_pkg::ROWS)) begin
          plan_o.scroll = 1'b1;
          row_n         = (tterm_pkg::ROW_W + 1)'(tterm_pkg::ROWS - 1);
        end
      end
      tterm_pkg::ACT_CLEAR: begin
        col_n = '0;
        row_n = '0;
      end
      tterm_pkg::ACT_BACKSPACE: begin
        // step back, erase, the second step lands on the erased cell
        plan_o.wr_en   = 1'b1;
        plan_o.wr_addr = tterm_pkg::cell_addr(row_q, col_dec);
        plan_o.wr_data = {back_i, fore_i, tterm_pkg::CHR_SPACE};
        col_n          = tterm_pkg::NEXT_W'(col_dec);
      end
      default: begin
      end
    endcase
  end

  assign row_d = row_n[tterm_pkg::ROW_W-1:0];
  assign col_d = col_n[tterm_pkg::COL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign cursor_o.row      = 5'(row_q);
  assign cursor_o.col      = 7'(col_q);
  assign cursor_o.location = 11'(tterm_pkg::cell_addr(row_q, col_q));

endmodule

@@ hw/rtl/tterm_seq.sv @@
// ----------------------------------------------------------------------------
// tterm_seq
// Request sequencer: cell store sweeps, scroll copy, reads and result register.
// ----------------------------------------------------------------------------
module tterm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tterm_pkg::in_item_t  in_item_i,
  output logic                 accept_o,
  input  tterm_pkg::plan_t     plan_i,
  input  tterm_pkg::cursor_t   cursor_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tterm_pkg::out_item_t out_item_o
);

  localparam int AW = tterm_pkg::ADDR_W;

  tterm_pkg::state_e state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              cnt_last;
  logic              pend_q, pend_d;
  logic              pend_copy_q, pend_copy_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic              read_ok_q, read_ok_d;
  logic              read_ok;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  tterm_pkg::out_item_t out_item_q, out_item_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  assign in_stall_o = (state_q != tterm_pkg::ST_IDLE);
  assign accept_o   = in_valid_i && !in_stall_o;
  assign cnt_last   = (cnt_q == AW'(tterm_pkg::CELL_COUNT - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign read_ok    = (in_item_i.action == tterm_pkg::ACT_READ) &&
                      (int'(in_item_i.read_index) < tterm_pkg::CELL_COUNT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tterm_pkg::ST_INIT: begin
        if (cnt_last) state_d = tterm_pkg::ST_IDLE;
      end
      tterm_pkg::ST_IDLE: begin
        if (accept_o) begin
          if (in_item_i.action == tterm_pkg::ACT_CLEAR) begin
            state_d = tterm_pkg::ST_CLEAR;
          end else if (plan_i.scroll) begin
            state_d = tterm_pkg::ST_SCROLL;
          end else begin
            state_d = tterm_pkg::ST_DONE;
          end
        end
      end
      tterm_pkg::ST_CLEAR, tterm_pkg::ST_SCROLL: begin
        if (cnt_last) state_d = tterm_pkg::ST_DONE;
      end
      tterm_pkg::ST_DONE: begin
        if (out_free) state_d = tterm_pkg::ST_IDLE;
      end
      default: state_d = tterm_pkg::ST_INIT;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_addr_d = cnt_q;
    pend_copy_d = (int'(cnt_q) < tterm_pkg::COPY_COUNT);
    read_ok_d   = read_ok_q;
    ram_we      = 1'b0;
    ram_waddr   = plan_i.wr_addr;
    ram_wdata   = plan_i.wr_data;
    ram_re      = 1'b0;
    ram_raddr   = AW'(in_item_i.read_index);
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      tterm_pkg::ST_INIT, tterm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = tterm_pkg::BLANK_WORD;
        cnt_d     = cnt_last ? '0 : cnt_q + 1'b1;
      end
      tterm_pkg::ST_SCROLL: begin
        // read the line below now, write it one up in the next cycle; the bottom line is blanked
        pend_d    = 1'b1;
        ram_re    = pend_copy_d;
        ram_raddr = AW'(cnt_q + AW'(tterm_pkg::COLUMNS));
        cnt_d     = cnt_last ? '0 : cnt_q + 1'b1;
      end
      tterm_pkg::ST_IDLE: begin
        if (accept_o) begin
          ram_we    = plan_i.wr_en;
          ram_re    = read_ok;
          read_ok_d = read_ok;
        end
      end
      tterm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_item_d.read_data       = read_ok_q ? ram_rdata : 16'h0000;
          out_item_d.cursor_row      = cursor_i.row;
          out_item_d.cursor_col      = cursor_i.col;
          out_item_d.cursor_location = cursor_i.location;
        end
      end
      default: begin
      end
    endcase
    // delayed scroll write takes the port
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_copy_q ? ram_rdata : tterm_pkg::BLANK_WORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tterm_pkg::ST_INIT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      read_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      read_ok_q   <= read_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_copy_q <= pend_copy_d;
    out_item_q  <= out_item_d;
  end

  tterm_ram #(
    .WIDTH(16),
    .DEPTH(tterm_pkg::CELL_COUNT)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a delayed scroll write never meets a write from a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> !accept_o)
    else $error("scroll write overlaps a new request");

  // the last delayed write lands in the first result cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tterm_pkg::ST_SCROLL && cnt_last) |=> (state_q == tterm_pkg::ST_DONE && pend_q))
    else $error("scroll did not finish into the result cycle");

  // a finished request is handed to the result register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tterm_pkg::ST_DONE && out_free) |=> (out_valid_q && state_q == tterm_pkg::ST_IDLE))
    else $error("result not loaded");

  // sweeps never leave the memory range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tterm_pkg::ST_INIT || state_q == tterm_pkg::ST_CLEAR ||
     state_q == tterm_pkg::ST_SCROLL) |-> (int'(cnt_q) < tterm_pkg::CELL_COUNT))
    else $error("sweep counter out of range");

endmodule

@@ hw/rtl/text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_writer
// Text console of character cells with cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// Every request gives one result. Put character, backspace with erase and
// read cell are handled in the request cycle, where the cursor moves and the
// cell store is written or read; the result register is then loaded as soon
// as it is free. Clear screen and a put that scrolls the screen also walk the
// cell store one entry a cycle through its single write port before the
// result is loaded; a scroll copies each line one up with a read now and a
// write in the next cycle. After reset the store is blanked, all CELL_COUNT
// cells, while in_stall_o stays high; colour register writes are taken at
// any time.
module text_terminal_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tterm_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tterm_pkg::out_item_t              out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tterm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tterm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [3:0]         back_q, back_d;
  logic [3:0]         fore_q, fore_d;
  logic               accept;
  tterm_pkg::plan_t   plan;
  tterm_pkg::cursor_t cursor;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    back_d = back_q;
    fore_d = fore_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tterm_pkg::CFG_BACK_COLOR: back_d = cfg_data_i;
        tterm_pkg::CFG_FORE_COLOR: fore_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q <= tterm_pkg::BACK_RESET;
      fore_q <= tterm_pkg::FORE_RESET;
    end else begin
      back_q <= back_d;
      fore_q <= fore_d;
    end
  end

  tterm_cursor u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .back_i  (back_q),
    .fore_i  (fore_q),
    .plan_o  (plan),
    .cursor_o(cursor)
  );

  tterm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .accept_o   (accept),
    .plan_i     (plan),
    .cursor_i   (cursor),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ dv/text_terminal_writer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_terminal_writer_tb
// Self-checking bench for the text console: a queue-fed driver and a clocked
// monitor are scored against a cycle-free model of the cell store and cursor,
// using directed requests, then random text, control codes, reads and noise
// under three sender and receiver idle profiles and several colour settings.
// ----------------------------------------------------------------------------
module text_terminal_writer_tb;

  localparam int BLOCKS       = 6;
  localparam int BLOCK_ITEMS  = 275;
  localparam int ITEM_BUDGET  = 1800;
  localparam int LIMIT_CYCLES = tterm_pkg::CELL_COUNT +
                                ITEM_BUDGET * (tterm_pkg::CELL_COUNT + 2 + 200) * 4;
  localparam int MAX_REPORTS  = 10;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  tterm_pkg::in_item_t  req_q    = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  tterm_pkg::out_item_t out_item_o;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready_o;
  logic [tterm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tterm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  text_terminal_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (req_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // console model state
  logic [15:0] screen_model [tterm_pkg::CELL_COUNT];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [3:0]  back_nib;
  logic [3:0]  fore_nib;

  tterm_pkg::in_item_t  pending_reqs[$];
  tterm_pkg::out_item_t awaited_results[$];
  int unsigned queued_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 68;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void console_put(input logic [7:0] code);
    int unsigned cell_idx;
    if (code == tterm_pkg::CHR_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (code == tterm_pkg::CHR_TAB) begin
      cur_col = cur_col + tterm_pkg::TAB_WIDTH - (cur_col % tterm_pkg::TAB_WIDTH);
    end else if (code == tterm_pkg::CHR_CR) begin
      cur_col = 0;
    end else if (code == tterm_pkg::CHR_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (code >= tterm_pkg::CHR_SPACE && code <= tterm_pkg::CHR_PRINT_MAX) begin
      cell_idx = cur_row * tterm_pkg::COLUMNS + cur_col;
      if (cell_idx < tterm_pkg::CELL_COUNT)
        screen_model[cell_idx] = {back_nib, fore_nib, code};
      cur_col++;
    end
    if (cur_col >= tterm_pkg::COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    // scroll every line up one and blank the bottom line
    if (cur_row >= tterm_pkg::ROWS) begin
      for (int i = 0; i < tterm_pkg::COPY_COUNT; i++)
        screen_model[i] = screen_model[i + tterm_pkg::COLUMNS];
      for (int i = tterm_pkg::COPY_COUNT; i < tterm_pkg::CELL_COUNT; i++)
        screen_model[i] = tterm_pkg::BLANK_WORD;
      cur_row = tterm_pkg::ROWS - 1;
    end
  endfunction

  function automatic tterm_pkg::out_item_t console_predict(input tterm_pkg::in_item_t req);
    tterm_pkg::out_item_t res;
    res = '0;
    case (req.action)
      tterm_pkg::ACT_PUT: begin
        console_put(req.char_code);
      end
      tterm_pkg::ACT_CLEAR: begin
        for (int i = 0; i < tterm_pkg::CELL_COUNT; i++) screen_model[i] = tterm_pkg::BLANK_WORD;
        cur_row = 0;
        cur_col = 0;
      end
      tterm_pkg::ACT_BACKSPACE: begin
        if (cur_col != 0) cur_col--;
        console_put(tterm_pkg::CHR_SPACE);
        if (cur_col != 0) cur_col--;
      end
      default: begin
        if (req.read_index < tterm_pkg::CELL_COUNT)
          res.read_data = screen_model[req.read_index];
      end
    endcase
    res.cursor_row      = 5'(cur_row);
    res.cursor_col      = 7'(cur_col);
    res.cursor_location = 11'(cur_row * tterm_pkg::COLUMNS + cur_col);
    return res;
  endfunction

  function automatic void push_req(input tterm_pkg::action_e act, input logic [7:0] code,
                                   input logic [10:0] idx);
    tterm_pkg::in_item_t r;
    r.action     = act;
    r.char_code  = code;
    r.read_index = idx;
    pending_reqs.push_back(r);
    queued_items++;
  endfunction

  function automatic logic [10:0] any_index();
    return 11'($urandom_range(2047));
  endfunction

  function automatic void gen_block(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned sub;
    int unsigned len;
    start = queued_items;
    while (queued_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // a line of text, sometimes longer than the screen is wide
        len = ($urandom_range(7) == 0) ? $urandom_range(100, 60) : $urandom_range(30, 1);
        for (int k = 0; k < len; k++) begin
          sub = $urandom_range(99);
          if (sub < 4) push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_TAB, any_index());
          else if (sub < 7) push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_BS, any_index());
          else if (sub < 9)
            push_req(tterm_pkg::ACT_BACKSPACE, 8'($urandom_range(255)), any_index());
          else
            push_req(tterm_pkg::ACT_PUT,
                     8'($urandom_range(tterm_pkg::CHR_PRINT_MAX, tterm_pkg::CHR_SPACE)),
                     any_index());
        end
        sub = $urandom_range(9);
        if (sub < 6) begin
          push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_LF, any_index());
        end else if (sub < 8) begin
          push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_CR, any_index());
          push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_LF, any_index());
        end else if (sub < 9) begin
          push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_CR, any_index());
        end
      end else if (pick < 65) begin
        len = $urandom_range(20, 1);
        for (int k = 0; k < len; k++)
          push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_LF, any_index());
      end else if (pick < 80) begin
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) begin
          sub = $urandom_range(9);
          if (sub < 7)
            push_req(tterm_pkg::ACT_READ, 8'($urandom_range(255)),
                     11'($urandom_range(tterm_pkg::CELL_COUNT - 1)));
          else if (sub < 9)
            push_req(tterm_pkg::ACT_READ, 8'($urandom_range(255)),
                     11'($urandom_range(tterm_pkg::CELL_COUNT - 1, tterm_pkg::COPY_COUNT)));
          else
            push_req(tterm_pkg::ACT_READ, 8'($urandom_range(255)), any_index());
        end
      end else if (pick < 88) begin
        sub = $urandom_range(2);
        len = (sub == 0) ? $urandom_range(25, 1) : $urandom_range(5, 1);
        for (int k = 0; k < len; k++) begin
          if (sub == 0) push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_TAB, any_index());
          else if (sub == 1) push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_BS, any_index());
          else push_req(tterm_pkg::ACT_BACKSPACE, 8'($urandom_range(255)), any_index());
        end
      end else if (pick < 89) begin
        push_req(tterm_pkg::ACT_CLEAR, 8'($urandom_range(255)), any_index());
      end else begin
        len = $urandom_range(3, 1);
        for (int k = 0; k < len; k++)
          push_req(tterm_pkg::action_e'($urandom_range(3)), 8'($urandom_range(255)),
                   any_index());
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tterm_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tterm_pkg::CFG_BACK_COLOR: back_nib = val;
      tterm_pkg::CFG_FORE_COLOR: fore_nib = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) awaited_results.push_back(console_predict(req_q));
      if (!in_valid || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          req_q    <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    tterm_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: data %h row %0d col %0d loc %0d",
                     out_item_o.read_data, out_item_o.cursor_row,
                     out_item_o.cursor_col, out_item_o.cursor_location);
        end else begin
          want = awaited_results.pop_front();
          if (out_item_o.read_data != want.read_data ||
              out_item_o.cursor_row != want.cursor_row ||
              out_item_o.cursor_col != want.cursor_col ||
              out_item_o.cursor_location != want.cursor_location) begin
            mismatch_count++;
            // pairs are expected/actual
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: data %h/%h row %0d/%0d col %0d/%0d loc %0d/%0d",
                       want.read_data, out_item_o.read_data,
                       want.cursor_row, out_item_o.cursor_row,
                       want.cursor_col, out_item_o.cursor_col,
                       want.cursor_location, out_item_o.cursor_location);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] back_set [BLOCKS];
    logic [3:0] fore_set [BLOCKS];
    back_set = '{4'hF, 4'h0, 4'hF, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'h0};
    fore_set = '{4'h0, 4'h0, 4'hF, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'hF};
    for (int i = 0; i < tterm_pkg::CELL_COUNT; i++) screen_model[i] = tterm_pkg::BLANK_WORD;
    cur_row  = 0;
    cur_col  = 0;
    back_nib = tterm_pkg::BACK_RESET;
    fore_nib = tterm_pkg::FORE_RESET;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, every action and the cursor corner cases
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'd0);
    push_req(tterm_pkg::ACT_READ, 8'hFF, 11'(tterm_pkg::CELL_COUNT - 1));
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'(tterm_pkg::CELL_COUNT));
    push_req(tterm_pkg::ACT_READ, 8'hFF, 11'h7FF);
    push_req(tterm_pkg::ACT_PUT, 8'h41, 11'h7FF);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_PRINT_MAX, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_SPACE, 11'd0);
    push_req(tterm_pkg::ACT_PUT, 8'h80, 11'd0);
    push_req(tterm_pkg::ACT_PUT, 8'hFF, 11'h7FF);
    push_req(tterm_pkg::ACT_PUT, 8'h00, 11'd0);
    push_req(tterm_pkg::ACT_PUT, 8'h1F, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_BS, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_TAB, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_TAB, 11'd0);
    push_req(tterm_pkg::ACT_BACKSPACE, 8'h00, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_CR, 11'd0);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_BS, 11'd0);
    push_req(tterm_pkg::ACT_BACKSPACE, 8'hFF, 11'h7FF);
    push_req(tterm_pkg::ACT_PUT, tterm_pkg::CHR_LF, 11'd0);
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'd0);
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'd7);
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'(tterm_pkg::COLUMNS));
    push_req(tterm_pkg::ACT_CLEAR, 8'hFF, 11'h7FF);
    push_req(tterm_pkg::ACT_READ, 8'h00, 11'd0);
    push_req(tterm_pkg::ACT_PUT, 8'h7A, 11'h7FF);
    wait_drained();

    for (int b = 0; b < BLOCKS; b++) begin
      if (b < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 68;
      end else if (b < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(tterm_pkg::CFG_BACK_COLOR, back_set[b]);
      write_reg(tterm_pkg::CFG_FORE_COLOR, fore_set[b]);
      gen_block(BLOCK_ITEMS);
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
